>>> rtl/core/pu_pkg.sv
// Shared types, codes and the factorial table for the permutation unranking block.
`timescale 1ns / 1ps

package pu_pkg;

  // Fixed field widths
  localparam int RANK_W  = 29;
  localparam int DIGIT_W = 4;
  // Index width carried in the word-store command; covers the largest allowed word
  localparam int IDX_PW  = 4;
  // Divider step counter: one quotient bit per step
  localparam int STEP_W  = $clog2(DIGIT_W);
  localparam int DIV_W   = RANK_W + DIGIT_W - 1;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_LEX    = 2'd1,
    FN_REVLEX = 2'd2,
    FN_FIKE   = 2'd3
  } pu_func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BAD,
    S_LADDER,
    S_DIV_GO,
    S_DIV_WAIT,
    S_LEX,
    S_FIKE_A,
    S_FIKE_B,
    S_EMIT
  } pu_state_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_LOAD,
    W_ROTATE,
    W_HOLD,
    W_SWAP
  } pu_wop_t;

  typedef struct packed {
    pu_wop_t           op;
    logic [IDX_PW-1:0] a_idx;
    logic [IDX_PW-1:0] b_idx;
    logic [IDX_PW-1:0] rd_addr;
  } pu_word_cmd_t;

  // n! for word lengths up to twelve
  function automatic logic [RANK_W-1:0] fact_f(input logic [DIGIT_W-1:0] n);
    logic [RANK_W-1:0] f;
    case (n)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = 29'd479001600;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/core/pu_div.sv
// Shared restoring divider: small quotient, one quotient bit per cycle.
`timescale 1ns / 1ps

module pu_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pu_pkg::RANK_W-1:0]  dividend,
  input  logic [pu_pkg::RANK_W-1:0]  divisor,
  output logic                       done,
  output logic [pu_pkg::DIGIT_W-1:0] quo,
  output logic [pu_pkg::RANK_W-1:0]  rem
);
  import pu_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   k_r;
  logic [RANK_W-1:0]   rem_r;
  logic [RANK_W-1:0]   div_r;
  logic [DIGIT_W-1:0]  quo_r;
  logic [DIV_W-1:0]    dsh;
  logic                ge;

  // trial subtract of the shifted divisor
  assign dsh = DIV_W'(div_r) << k_r;
  assign ge  = (DIV_W'(rem_r) >= dsh);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= STEP_W'(DIGIT_W - 1);
      end else if (busy_r) begin
        k_r <= k_r - STEP_W'(1);
        if (k_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      quo_r[k_r] <= ge;
      if (ge) begin
        rem_r <= rem_r - dsh[RANK_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && busy_r))
    else $error("divider started while running");

  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && ($past(k_r) == '0)))
    else $error("divider done without finishing its steps");

  a_start_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && (k_r == STEP_W'(DIGIT_W - 1))))
    else $error("divider did not begin at the top quotient bit");
`endif

endmodule

>>> rtl/core/pu_word.sv
// Symbol register file: load, remove-and-rotate, and hold-then-swap operations.
`timescale 1ns / 1ps

module pu_word #(
  parameter int MAX_LEN     = 12,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                     clk,
  input  pu_pkg::pu_word_cmd_t     cmd,
  input  logic [SYMBOL_BITS-1:0]   wdata,
  output logic [SYMBOL_BITS-1:0]   rd_data
);
  import pu_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [SYMBOL_BITS-1:0] word_r [MAX_LEN];
  logic [SYMBOL_BITS-1:0] hold_r;
  logic [SYMBOL_BITS-1:0] up_val [MAX_LEN];
  logic [IDX_W-1:0]       a_idx;
  logic [IDX_W-1:0]       b_idx;
  logic [IDX_W-1:0]       rd_idx;

  assign a_idx  = cmd.a_idx[IDX_W-1:0];
  assign b_idx  = cmd.b_idx[IDX_W-1:0];
  assign rd_idx = cmd.rd_addr[IDX_W-1:0];

  // single read port
  assign rd_data = word_r[rd_idx];

  // neighbor above each entry, for the removal shift
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_up
    if (g == MAX_LEN - 1) begin : g_top
      assign up_val[g] = word_r[g];
    end else begin : g_mid
      assign up_val[g] = word_r[g + 1];
    end
  end

  // entry updates
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_LEN; j++) begin
      case (cmd.op)
        W_LOAD: begin
          if (IDX_W'(j) == a_idx) word_r[j] <= wdata;
        end
        W_ROTATE: begin
          // picked entry goes to the top of the live list, the rest close up
          if (IDX_W'(j) == b_idx) begin
            word_r[j] <= rd_data;
          end else if ((IDX_W'(j) >= a_idx) && (IDX_W'(j) < b_idx)) begin
            word_r[j] <= up_val[j];
          end
        end
        W_SWAP: begin
          if (IDX_W'(j) == b_idx) begin
            word_r[j] <= hold_r;
          end else if (IDX_W'(j) == a_idx) begin
            word_r[j] <= rd_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // swap holding register
  always_ff @(posedge clk) begin
    if (cmd.op == W_HOLD) hold_r <= rd_data;
  end

endmodule

>>> rtl/core/permutation_unrank.sv
// Permutation unranking top level: loads symbols, then emits the chosen permutation.
// Load item: busy stays low. Invalid compute: busy for one cycle, one result next.
// Compute on n >= 2 symbols: an (n-1)-entry place-value ladder, then n-1 digits on the shared
// divider, then n-1 removal steps (n-1 hold-and-swap pairs for Fike order), then n results,
// one per cycle.
// Reset (rst_n low, synchronous) empties the word and returns the sequencer to idle.
`timescale 1ns / 1ps

module permutation_unrank #(
  parameter int MAX_LEN     = 12,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_func,
  input  logic [SYMBOL_BITS-1:0]     in_symbol,
  input  logic [pu_pkg::RANK_W-1:0]  in_rank,
  output logic                       out_valid,
  output logic [SYMBOL_BITS-1:0]     out_symbol,
  output logic [pu_pkg::DIGIT_W-1:0] out_code_digit,
  output logic                       out_last,
  output logic                       out_invalid
);
  import pu_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  pu_state_t          state_r, state_nxt;
  pu_func_t           func_r, func_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [RANK_W-1:0]  r_r, r_nxt;
  logic [RANK_W-1:0]  prod_r, prod_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SYMBOL_BITS-1:0] out_symbol_r, out_symbol_nxt;
  logic [DIGIT_W-1:0]     out_digit_r, out_digit_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_invalid_r, out_invalid_nxt;

  // place values and extracted digits
  logic [RANK_W-1:0]  place_r [MAX_LEN];
  logic [DIGIT_W-1:0] digit_r [MAX_LEN];
  logic               place_we;
  logic               digit_we;
  logic [DIGIT_W-1:0] digit_wd;

  // shared units
  logic               div_start;
  logic               div_done;
  logic [DIGIT_W-1:0] div_quo;
  logic [RANK_W-1:0]  div_rem;
  pu_word_cmd_t       wcmd;
  logic [SYMBOL_BITS-1:0] rd_data;

  // helpers
  pu_func_t                  in_fn;
  logic [CNT_W-1:0]          i_ext;
  logic                      at_last_digit;
  logic                      at_last_pos;
  logic [DIGIT_W-1:0]        n4;
  logic [DIGIT_W-1:0]        i4;
  logic [DIGIT_W-1:0]        ip1;
  logic [DIGIT_W-1:0]        factor;
  logic [RANK_W+DIGIT_W-1:0] prod_full;
  logic [DIGIT_W-1:0]        fike_q;
  logic [DIGIT_W-1:0]        cur_digit;
  logic [DIGIT_W-1:0]        len4;
  logic [DIGIT_W-1:0]        lex_p;
  logic [DIGIT_W-1:0]        lex_q;
  logic [DIGIT_W-1:0]        fike_p;
  logic [IDX_W-1:0]          emit_addr;

  assign in_fn         = pu_func_t'(in_func);
  assign i_ext         = CNT_W'(i_r);
  assign at_last_digit = (i_ext == (n_r - CNT_W'(2)));
  assign at_last_pos   = (i_ext == (n_r - CNT_W'(1)));
  assign n4            = DIGIT_W'(n_r);
  assign i4            = DIGIT_W'(i_r);
  assign ip1           = i4 + DIGIT_W'(1);
  assign cur_digit     = digit_r[i_r];

  // place-value ladder: Fike scales by (i+2), lexicographic by (n-i)
  assign factor    = (func_r == FN_FIKE) ? (i4 + DIGIT_W'(2)) : (n4 - i4);
  assign prod_full = prod_r * factor;

  // Fike swap index from the quotient, clamped
  assign fike_q = (div_quo > ip1) ? ip1 : div_quo;

  // lexicographic pick, counted from the end of the live list in reverse order
  assign len4  = n4 - i4;
  assign lex_p = (cur_digit >= len4) ? (len4 - DIGIT_W'(1)) : cur_digit;
  assign lex_q = (func_r == FN_REVLEX) ? (len4 - DIGIT_W'(1) - lex_p) : lex_p;

  assign fike_p = (cur_digit >= n4) ? (n4 - DIGIT_W'(1)) : cur_digit;

  // lexicographic picks sit top-down in the store; reverse and Fike read bottom-up
  assign emit_addr = (func_r == FN_LEX) ? IDX_W'(n_r - CNT_W'(1) - i_ext) : i_r;

  pu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (r_r),
    .divisor  (place_r[i_r]),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  pu_word #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_word (
    .clk     (clk),
    .cmd     (wcmd),
    .wdata   (in_symbol),
    .rd_data (rd_data)
  );

  // sequencer: next state and controls
  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    cnt_nxt         = cnt_r;
    n_nxt           = n_r;
    i_nxt           = i_r;
    r_nxt           = r_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = 1'b0;
    out_symbol_nxt  = out_symbol_r;
    out_digit_nxt   = out_digit_r;
    out_last_nxt    = out_last_r;
    out_invalid_nxt = out_invalid_r;
    place_we        = 1'b0;
    digit_we        = 1'b0;
    digit_wd        = div_quo;
    div_start       = 1'b0;
    wcmd            = '{op: W_NONE, a_idx: '0, b_idx: '0, rd_addr: '0};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_fn == FN_LOAD) begin
            if (cnt_r < MAX_CNT) begin
              wcmd.op    = W_LOAD;
              wcmd.a_idx = IDX_PW'(cnt_r);
              cnt_nxt    = cnt_r + CNT_W'(1);
            end
          end else begin
            cnt_nxt  = '0;
            n_nxt    = cnt_r;
            func_nxt = in_fn;
            r_nxt    = in_rank - RANK_W'(1);
            prod_nxt = RANK_W'(1);
            i_nxt    = IDX_W'(cnt_r - CNT_W'(2));
            if ((cnt_r == '0) || (in_rank == '0) ||
                (in_rank > fact_f(DIGIT_W'(cnt_r)))) begin
              state_nxt = S_BAD;
            end else if (cnt_r == CNT_W'(1)) begin
              i_nxt     = '0;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_LADDER;
            end
          end
        end
      end

      S_BAD: begin
        out_valid_nxt   = 1'b1;
        out_symbol_nxt  = '0;
        out_digit_nxt   = '0;
        out_last_nxt    = 1'b1;
        out_invalid_nxt = 1'b1;
        state_nxt       = S_IDLE;
      end

      // place values from the least significant digit upward
      S_LADDER: begin
        place_we = 1'b1;
        prod_nxt = prod_full[RANK_W-1:0];
        if (i_r == '0) begin
          state_nxt = S_DIV_GO;
        end else begin
          i_nxt = i_r - IDX_W'(1);
        end
      end

      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          digit_we = 1'b1;
          digit_wd = (func_r == FN_FIKE) ? (ip1 - fike_q) : div_quo;
          r_nxt    = div_rem;
          if (at_last_digit) begin
            i_nxt     = '0;
            state_nxt = (func_r == FN_FIKE) ? S_FIKE_A : S_LEX;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_DIV_GO;
          end
        end
      end

      // pick one entry, close the gap, park the pick above the live list
      S_LEX: begin
        wcmd.op      = W_ROTATE;
        wcmd.a_idx   = IDX_PW'(lex_q);
        wcmd.b_idx   = IDX_PW'(len4 - DIGIT_W'(1));
        wcmd.rd_addr = IDX_PW'(lex_q);
        if (at_last_digit) begin
          i_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end

      S_FIKE_A: begin
        wcmd.op      = W_HOLD;
        wcmd.rd_addr = IDX_PW'(ip1);
        state_nxt    = S_FIKE_B;
      end

      S_FIKE_B: begin
        wcmd.op      = W_SWAP;
        wcmd.a_idx   = IDX_PW'(ip1);
        wcmd.b_idx   = IDX_PW'(fike_p);
        wcmd.rd_addr = IDX_PW'(fike_p);
        if (at_last_digit) begin
          i_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_FIKE_A;
        end
      end

      S_EMIT: begin
        wcmd.rd_addr    = IDX_PW'(emit_addr);
        out_valid_nxt   = 1'b1;
        out_symbol_nxt  = rd_data;
        out_digit_nxt   = at_last_pos ? '0 : cur_digit;
        out_last_nxt    = at_last_pos;
        out_invalid_nxt = 1'b0;
        if (at_last_pos) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    n_r           <= n_nxt;
    i_r           <= i_nxt;
    r_r           <= r_nxt;
    prod_r        <= prod_nxt;
    out_symbol_r  <= out_symbol_nxt;
    out_digit_r   <= out_digit_nxt;
    out_last_r    <= out_last_nxt;
    out_invalid_r <= out_invalid_nxt;
    if (place_we) place_r[i_r] <= prod_r;
    if (digit_we) digit_r[i_r] <= digit_wd;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_symbol     = out_symbol_r;
  assign out_code_digit = out_digit_r;
  assign out_last       = out_last_r;
  assign out_invalid    = out_invalid_r;

`ifndef SYNTHESIS
  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_invalid_r) |-> out_last_r)
    else $error("invalid result not marked last");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == S_IDLE))
    else $error("sequencer still running after the final result");

  a_compute_empties_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func != FN_LOAD)) |=> (cnt_r == '0))
    else $error("word not emptied by a compute item");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("word count beyond capacity");
`endif

endmodule
